FILE: rtl/trpc_pkg.sv
// Shared types, constants and the arctangent table for the pursuit controller.
// No dependencies; imported by every module of the block.
package trpc_pkg;

  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int POS_FRAC_BITS_DEF = 16;
  localparam int ATAN_ROWS         = 24;
  localparam int CORDIC_W          = 36;  // CORDIC x/y datapath width
  localparam int MUL_A_W           = 64;  // serial multiplier multiplicand width
  localparam int MUL_B_W           = 36;  // serial multiplier multiplier width

  localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;
  localparam logic [21:0] PI_Q20          = 22'd3294199;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_START_A = 3'd0;
  localparam logic [2:0] REG_START_B = 3'd1;
  localparam logic [2:0] REG_DIST_GN = 3'd2;
  localparam logic [2:0] REG_TURN_GN = 3'd3;
  localparam logic [2:0] REG_STOP    = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_ROT, ST_POSE, ST_WRPOSE, ST_VECGO, ST_VEC,
    ST_MAG, ST_CMP, ST_LIN, ST_T1, ST_T2, ST_DONE
  } trpc_state_t;

  typedef struct packed {
    logic start;
    logic vec_mode;
  } cordic_ctrl_t;

  function automatic logic [31:0] atan_row(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/two_robot_pursuit_controller_top.sv
// Pursuit controller top: pose update and steering for two robots.
// One item at a time: the input stalls while an item is in work, and the next
// transaction can be taken in the cycle after the result is loaded.
// Processing time is set by the bit-serial multiplier, shared by the eight products,
// and by the iterative CORDIC, used once for sin/cos and once for atan2/length.
// A result may wait in the output register while the next item is accepted.
// Synchronous reset clears poses, first-sample flags, registers and control.
module two_robot_pursuit_controller_top #(
  parameter int CORDIC_STEPS  = trpc_pkg::CORDIC_STEPS_DEF,
  parameter int POS_FRAC_BITS = trpc_pkg::POS_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic signed [31:0] odom_x,
  input  logic signed [31:0] odom_y,
  input  logic signed [15:0] odom_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               robot_id,
  output logic [15:0]        linear_cmd,
  output logic signed [16:0] angular_cmd,
  output logic               moving
);
  import trpc_pkg::*;

  trpc_state_t state, state_next;

  // Configuration
  logic [47:0] start_pose_a, start_pose_b;
  logic [15:0] distance_gain, turn_gain;
  logic [30:0] stop_distance;

  // Per-robot state
  logic               seen_flag [2];
  logic signed [31:0] ref_x [2], ref_y [2];
  logic [15:0]        ref_heading [2];
  logic signed [31:0] pose_x [2], pose_y [2];
  logic [15:0]        pose_heading [2];

  // Item working registers
  logic               r_q;
  logic signed [31:0] ox_q, oy_q;
  logic [15:0]        oh_q;
  logic signed [32:0] dx, dy;
  logic signed [37:0] sx, sy, acc_x, acc_y;
  logic [15:0]        sh;
  logic               rot_neg;
  logic signed [33:0] cos_q, sin_q;
  logic [1:0]         k;
  logic [33:0]        mag;
  logic [31:0]        tang;
  logic signed [23:0] e24;
  logic signed [39:0] t1;
  logic [15:0]        lin_q;
  logic signed [16:0] ang_q;
  logic               moving_q;
  logic               mul_pend;

  // Unit connections
  cordic_ctrl_t               cctrl;
  logic signed [CORDIC_W-1:0] c_x0, c_y0, c_x, c_y;
  logic [31:0]                c_z0, c_z;
  logic                       c_done;
  logic                       mul_start, mul_done;
  logic signed [MUL_A_W-1:0]  mul_a, mul_p;
  logic signed [MUL_B_W-1:0]  mul_b;

  logic        in_take, out_take, go_move;
  logic [47:0] sp;
  logic signed [31:0] zf;
  logic [15:0] rot16;
  logic signed [32:0] tx, ty;
  logic signed [MUL_A_W-1:0] rnd, ang_sum, ang_full;
  logic [MUL_A_W-1:0]        lin_sum, lin_full, mag_sum;
  logic [31:0]               err;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign go_move  = {1'b0, mag} > {4'd0, stop_distance};

  trpc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .ctrl(cctrl), .x0(c_x0), .y0(c_y0), .z0(c_z0),
    .done(c_done), .x(c_x), .y(c_y), .z(c_z)
  );

  trpc_serial_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  // Derived values used by the datapath
  always_comb begin
    sp    = r_q ? start_pose_b : start_pose_a;
    rot16 = ref_heading[r_q] + sp[15:0];
    zf    = $signed({rot16, 16'h0});
    if (zf > 32'sh4000_0000) begin
      zf = zf - 32'sh8000_0000;
    end else if (zf < -32'sh4000_0000) begin
      zf = zf + 32'sh8000_0000;
    end
    tx       = 33'(pose_x[~r_q]) - 33'(pose_x[r_q]);
    ty       = 33'(pose_y[~r_q]) - 33'(pose_y[r_q]);
    rnd      = (mul_p + (64'sd1 <<< 29)) >>> 30;
    mag_sum  = 64'(mul_p) + (64'd1 << 29);
    lin_sum  = 64'(mul_p) + (64'd1 << (POS_FRAC_BITS - 8));
    lin_full = lin_sum >> (POS_FRAC_BITS - 7);
    ang_sum  = mul_p + (64'sd1 <<< 35);
    ang_full = ang_sum >>> 36;
    err      = tang - {pose_heading[r_q], 16'h0};
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_PREP;
      ST_PREP:   state_next = ST_ROT;
      ST_ROT:    if (c_done) state_next = ST_POSE;
      ST_POSE:   if (mul_done && k == 2'd3) state_next = ST_WRPOSE;
      ST_WRPOSE: state_next = ST_VECGO;
      ST_VECGO:  state_next = ST_VEC;
      ST_VEC:    if (c_done) state_next = ST_MAG;
      ST_MAG:    if (mul_done) state_next = ST_CMP;
      ST_CMP:    state_next = go_move ? ST_LIN : ST_DONE;
      ST_LIN:    if (mul_done) state_next = ST_T1;
      ST_T1:     if (mul_done) state_next = ST_T2;
      ST_T2:     if (mul_done) state_next = ST_DONE;
      ST_DONE:   if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs to the units and the input channel
  always_comb begin
    in_stall       = (state != ST_IDLE);
    cctrl.start    = (state == ST_PREP) || (state == ST_VECGO);
    cctrl.vec_mode = (state == ST_VECGO);
    c_x0 = CORDIC_W'($signed({1'b0, CORDIC_GAIN_Q30}));
    c_y0 = '0;
    c_z0 = zf;
    if (state == ST_VECGO) begin
      if (tx < 0) begin
        c_x0 = -CORDIC_W'(tx);
        c_y0 = -CORDIC_W'(ty);
        c_z0 = 32'h8000_0000;
      end else begin
        c_x0 = CORDIC_W'(tx);
        c_y0 = CORDIC_W'(ty);
        c_z0 = 32'h0;
      end
    end
    mul_start = mul_pend;
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_POSE: begin
        mul_a = k[1] ? MUL_A_W'(dx) : MUL_A_W'(dx);
        if (k == 2'd1 || k == 2'd3) mul_a = MUL_A_W'(dy);
        mul_b = (k == 2'd0 || k == 2'd3) ? MUL_B_W'(cos_q) : MUL_B_W'(sin_q);
      end
      ST_MAG: begin
        mul_a = MUL_A_W'(c_x[CORDIC_W-1] ? '0 : c_x);
        mul_b = MUL_B_W'($signed({1'b0, CORDIC_GAIN_Q30}));
      end
      ST_LIN: begin
        mul_a = MUL_A_W'($signed({1'b0, mag}));
        mul_b = MUL_B_W'($signed({1'b0, distance_gain}));
      end
      ST_T1: begin
        mul_a = MUL_A_W'(e24);
        mul_b = MUL_B_W'($signed({1'b0, turn_gain}));
      end
      ST_T2: begin
        mul_a = MUL_A_W'(t1);
        mul_b = MUL_B_W'($signed({1'b0, PI_Q20}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Control, configuration and per-robot state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      mul_pend      <= 1'b0;
      k             <= '0;
      start_pose_a  <= '0;
      start_pose_b  <= '0;
      distance_gain <= 16'd256;
      turn_gain     <= 16'd256;
      stop_distance <= 31'd6554;
      for (int i = 0; i < 2; i++) begin
        seen_flag[i]    <= 1'b0;
        pose_x[i]       <= '0;
        pose_y[i]       <= '0;
        pose_heading[i] <= '0;
      end
    end else begin
      state    <= state_next;
      mul_pend <= 1'b0;
      if (out_take) out_valid <= 1'b0;

      // Register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_START_A: start_pose_a  <= cfg_data;
          REG_START_B: start_pose_b  <= cfg_data;
          REG_DIST_GN: distance_gain <= cfg_data[15:0];
          REG_TURN_GN: turn_gain     <= cfg_data[15:0];
          REG_STOP:    stop_distance <= cfg_data[30:0];
          default: ;
        endcase
      end

      // Latch the transaction; first sample of a robot sets its reference
      if (in_take) begin
        r_q  <= action;
        ox_q <= odom_x;
        oy_q <= odom_y;
        oh_q <= odom_heading;
        if (!seen_flag[action]) begin
          seen_flag[action]   <= 1'b1;
          ref_x[action]       <= odom_x;
          ref_y[action]       <= odom_y;
          ref_heading[action] <= odom_heading;
        end
      end

      case (state)
        ST_PREP: begin
          dx      <= 33'(ox_q) - 33'(ref_x[r_q]);
          dy      <= 33'(oy_q) - 33'(ref_y[r_q]);
          sx      <= 38'($signed(sp[47:32])) <<< (POS_FRAC_BITS - 8);
          sy      <= 38'($signed(sp[31:16])) <<< (POS_FRAC_BITS - 8);
          sh      <= sp[15:0];
          rot_neg <= ($signed({rot16, 16'h0}) > 32'sh4000_0000) ||
                     ($signed({rot16, 16'h0}) < -32'sh4000_0000);
        end
        ST_ROT: if (c_done) begin
          cos_q    <= rot_neg ? -34'(c_x) : 34'(c_x);
          sin_q    <= rot_neg ? -34'(c_y) : 34'(c_y);
          acc_x    <= sx;
          acc_y    <= sy;
          k        <= '0;
          mul_pend <= 1'b1;
        end
        // Accumulate the four rounded rotation products
        ST_POSE: if (mul_done) begin
          case (k)
            2'd0, 2'd1: acc_x <= acc_x + 38'(rnd);
            2'd2:       acc_y <= acc_y - 38'(rnd);
            default:    acc_y <= acc_y + 38'(rnd);
          endcase
          if (k != 2'd3) begin
            k        <= k + 1'b1;
            mul_pend <= 1'b1;
          end
        end
        // Saturate and store the new pose
        ST_WRPOSE: begin
          if (acc_x > 38'sd2147483647)       pose_x[r_q] <= 32'sh7FFF_FFFF;
          else if (acc_x < -38'sd2147483648) pose_x[r_q] <= 32'sh8000_0000;
          else                               pose_x[r_q] <= 32'(acc_x);
          if (acc_y > 38'sd2147483647)       pose_y[r_q] <= 32'sh7FFF_FFFF;
          else if (acc_y < -38'sd2147483648) pose_y[r_q] <= 32'sh8000_0000;
          else                               pose_y[r_q] <= 32'(acc_y);
          pose_heading[r_q] <= sh + oh_q - ref_heading[r_q];
        end
        ST_VEC: if (c_done) begin
          tang     <= c_z;
          mul_pend <= 1'b1;
        end
        ST_MAG: if (mul_done) mag <= mag_sum[63:30];
        ST_CMP: begin
          moving_q <= go_move;
          lin_q    <= '0;
          ang_q    <= '0;
          e24      <= $signed(err[31:8]);
          mul_pend <= go_move;
        end
        ST_LIN: if (mul_done) begin
          lin_q    <= (lin_full > 64'd32768) ? 16'd32768 : lin_full[15:0];
          mul_pend <= 1'b1;
        end
        ST_T1: if (mul_done) begin
          t1       <= 40'(mul_p);
          mul_pend <= 1'b1;
        end
        // Clip the turn command to plus or minus one
        ST_T2: if (mul_done) begin
          if (ang_full > 64'sd32768)       ang_q <= 17'sh08000;
          else if (ang_full < -64'sd32768) ang_q <= 17'sh18000;
          else                             ang_q <= 17'(ang_full);
        end
        // Hand the result to the output register once it is free
        ST_DONE: if (!out_valid || !out_stall) begin
          out_valid   <= 1'b1;
          robot_id    <= r_q;
          linear_cmd  <= lin_q;
          angular_cmd <= ang_q;
          moving      <= moving_q;
        end
        default: ;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state == ST_PREP)
    else $error("accepted transaction did not start work");

  a_mul_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_POSE || state == ST_MAG || state == ST_LIN ||
                  state == ST_T1 || state == ST_T2))
    else $error("multiplier finished outside a product state");

  a_cordic_state: assert property (@(posedge clk) disable iff (rst)
    c_done |-> (state == ST_ROT || state == ST_VEC))
    else $error("CORDIC finished outside a CORDIC state");

  a_stopped_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !moving) |-> (linear_cmd == 16'd0 && angular_cmd == 17'sd0))
    else $error("non-zero command while stopped");

  a_lin_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> linear_cmd <= 16'd32768)
    else $error("linear command above cap");

endmodule

FILE: rtl/trpc_serial_mul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-and-add.
// Depends on trpc_pkg for operand widths.
module trpc_serial_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [trpc_pkg::MUL_A_W-1:0] a,
  input  logic signed [trpc_pkg::MUL_B_W-1:0] b,
  output logic                              done,
  output logic signed [trpc_pkg::MUL_A_W-1:0] p
);
  import trpc_pkg::*;

  localparam int CNT_W = $clog2(MUL_B_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_B_W - 1);

  logic signed [MUL_A_W-1:0] acc;
  logic signed [MUL_A_W-1:0] a_sh;
  logic        [MUL_B_W-1:0] b_sh;
  logic        [CNT_W-1:0]   cnt;
  logic                      busy;

  // Shift the multiplier out one bit a cycle; the sign bit weighs negative
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        acc  <= '0;
        a_sh <= a;
        b_sh <= b;
        cnt  <= '0;
      end else if (busy) begin
        if (b_sh[0]) begin
          acc <= (cnt == LAST) ? acc - a_sh : acc + a_sh;
        end
        a_sh <= a_sh <<< 1;
        b_sh <= b_sh >> 1;
        cnt  <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign p = acc;

endmodule

FILE: rtl/trpc_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on trpc_pkg for the arctangent table and control struct.
module trpc_cordic #(
  parameter int CORDIC_STEPS = trpc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  trpc_pkg::cordic_ctrl_t               ctrl,
  input  logic signed [trpc_pkg::CORDIC_W-1:0] x0,
  input  logic signed [trpc_pkg::CORDIC_W-1:0] y0,
  input  logic        [31:0]                   z0,
  output logic                                 done,
  output logic signed [trpc_pkg::CORDIC_W-1:0] x,
  output logic signed [trpc_pkg::CORDIC_W-1:0] y,
  output logic        [31:0]                   z
);
  import trpc_pkg::*;

  localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [CW-1:0] LAST = CW'(CORDIC_STEPS - 1);

  logic          busy;
  logic          vec_mode;
  logic [CW-1:0] cnt;
  logic signed [CORDIC_W-1:0] xs, ys;
  logic [31:0]   at;
  logic          up;

  // Shifted terms and direction of this micro-rotation
  always_comb begin
    xs = x >>> cnt;
    ys = y >>> cnt;
    at = atan_row(5'(cnt));
    up = vec_mode ? y[CORDIC_W-1] : ~z[31];
  end

  // Load, then iterate the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy     <= 1'b1;
        vec_mode <= ctrl.vec_mode;
        cnt      <= '0;
        x        <= x0;
        y        <= y0;
        z        <= z0;
      end else if (busy) begin
        if (up) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: verif/tb_two_robot_pursuit_controller_top.sv
// Testbench for the two-robot pursuit controller: directed table, then random samples.
// Depends on rtl/trpc_pkg.sv and rtl/two_robot_pursuit_controller_top.sv.
`timescale 1ns / 1ps

module tb_two_robot_pursuit_controller_top;
  import trpc_pkg::*;

  localparam int LATENCY    = 2 * CORDIC_STEPS_DEF + 8 * 38 + 7;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [2:0] REG_UNUSED = 3'd7;  // index past the register list

  typedef struct {
    logic        rid;
    logic [15:0] lin;
    logic [16:0] ang;
    logic        mov;
  } cmd_t;

  typedef struct {
    logic        act;
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] h;
    logic        known;  // expected command typed in below
    cmd_t        cmd;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic signed [31:0] odom_x = '0;
  logic signed [31:0] odom_y = '0;
  logic signed [15:0] odom_heading = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic robot_id;
  logic [15:0] linear_cmd;
  logic signed [16:0] angular_cmd;
  logic moving;

  // predictor state
  logic [47:0] m_start[2];
  logic [15:0] m_dgain, m_tgain;
  logic [30:0] m_stop;
  logic        m_seen[2];
  logic signed [63:0] m_refx[2], m_refy[2], m_posx[2], m_posy[2];
  logic [15:0] m_refh[2], m_posh[2];

  cmd_t pending_cmds[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  bit   hold_long = 1'b0;

  two_robot_pursuit_controller_top u_dut (.*);

  always #1 clk = ~clk;

  function automatic logic [31:0] atan_step(int i);
    logic [31:0] t[24] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146,
      32'h000000A3, 32'h00000051};
    return t[i];
  endfunction

  function automatic logic signed [63:0] round_q30(logic signed [63:0] v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Rotate mode: cos and sin of a 32-bit binary angle, Q1.30
  task automatic sincos(input logic [31:0] ang, output logic signed [63:0] c,
                        output logic signed [63:0] s);
    logic signed [63:0] z, x, y, nx;
    bit flip;
    z = $signed({32'd0, ang});
    x = 64'sd652032874;
    y = 0;
    flip = 0;
    if (z >= (64'sd1 <<< 31)) z -= (64'sd1 <<< 32);
    if (z > (64'sd1 <<< 30)) begin
      z -= (64'sd1 <<< 31); flip = 1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += (64'sd1 <<< 31); flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= $signed({32'd0, atan_step(i)});
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += $signed({32'd0, atan_step(i)});
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Vector mode: length and bearing of (x, y)
  task automatic length_bearing(input logic signed [63:0] xi, input logic signed [63:0] yi,
                                output logic [63:0] mag, output logic [31:0] ang);
    logic signed [63:0] x, y, nx;
    logic [31:0] z;
    x = xi; y = yi; z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      if (y < 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_step(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_step(i);
      end
      x = nx;
    end
    if (x < 0) x = 0;
    mag = (x * 64'd652032874 + (64'd1 << 29)) >> 30;
    ang = z;
  endtask

  task automatic predictor_reset();
    m_start[0] = '0; m_start[1] = '0;
    m_dgain = 16'd256; m_tgain = 16'd256; m_stop = 31'd6554;
    for (int r = 0; r < 2; r++) begin
      m_seen[r] = 0; m_refx[r] = 0; m_refy[r] = 0; m_refh[r] = 0;
      m_posx[r] = 0; m_posy[r] = 0; m_posh[r] = 0;
    end
  endtask

  // Update the robot's pose and work out its steering command
  task automatic predict_command(input logic act, input logic [31:0] ox_u,
                                 input logic [31:0] oy_u, input logic [15:0] oh,
                                 output cmd_t res);
    int r, o;
    logic signed [63:0] ox, oy, sx, sy, c, s, dx, dy, tx, ty, es, e24, angv;
    logic [15:0] sh;
    logic [31:0] rot, tang, e;
    logic [63:0] mag, lin;
    r = act; o = 1 - r;
    ox = $signed(ox_u); oy = $signed(oy_u);
    if (!m_seen[r]) begin
      m_refx[r] = ox; m_refy[r] = oy; m_refh[r] = oh; m_seen[r] = 1;
    end
    sx = $signed(m_start[r][47:32]) * 256;
    sy = $signed(m_start[r][31:16]) * 256;
    sh = m_start[r][15:0];
    rot = {16'(m_refh[r] + sh), 16'd0};
    sincos(rot, c, s);
    dx = ox - m_refx[r];
    dy = oy - m_refy[r];
    m_posx[r] = clamp32(sx + round_q30(dx * c) + round_q30(dy * s));
    m_posy[r] = clamp32(sy - round_q30(dx * s) + round_q30(dy * c));
    m_posh[r] = sh + oh - m_refh[r];
    tx = m_posx[o] - m_posx[r];
    ty = m_posy[o] - m_posy[r];
    length_bearing(tx, ty, mag, tang);
    res.rid = act; res.lin = 0; res.ang = 0; res.mov = 0;
    if (mag > {33'd0, m_stop}) begin
      e = tang - {m_posh[r], 16'd0};
      es = $signed(e);
      e24 = es >>> 8;
      angv = (e24 * $signed({48'd0, m_tgain}) * 64'sd3294199 + (64'sd1 <<< 35)) >>> 36;
      if (angv > 32768) angv = 32768;
      if (angv < -32768) angv = -32768;
      lin = (mag * m_dgain + 64'd256) >> 9;
      if (lin > 32768) lin = 32768;
      res.lin = lin[15:0]; res.ang = angv[16:0]; res.mov = 1;
    end
  endtask

  // Present one register write; the caller drops the write enable after the last one
  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_START_A: m_start[0] = val;
      REG_START_B: m_start[1] = val;
      REG_DIST_GN: m_dgain = val[15:0];
      REG_TURN_GN: m_tgain = val[15:0];
      REG_STOP:    m_stop = val[30:0];
      default: ;
    endcase
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 400);
  endfunction

  // Offer one sample and hold it until the block takes it
  task automatic send_sample(input logic act, input logic [31:0] x, input logic [31:0] y,
                             input logic [15:0] h, input bit known, input cmd_t typed);
    cmd_t exp_cmd;
    predict_command(act, x, y, h, exp_cmd);
    if (known) exp_cmd = typed;
    in_valid <= 1'b1; action <= act; odom_x <= x; odom_y <= y; odom_heading <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_cmds.push_back(exp_cmd);
  endtask

  task automatic send_with_gap(input logic act, input logic [31:0] x, input logic [31:0] y,
                               input logic [15:0] h);
    int g;
    cmd_t none;
    none = '{0, 0, 0, 0};
    send_sample(act, x, y, h, 0, none);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() > 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  // Check each command against the oldest expectation
  always @(posedge clk) begin
    cmd_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected command rid=%0d lin=%0d ang=%0d mov=%0d",
                                       robot_id, linear_cmd, angular_cmd, moving);
      end else begin
        want = pending_cmds.pop_front();
        if (robot_id !== want.rid || linear_cmd !== want.lin || angular_cmd !== want.ang ||
            moving !== want.mov) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp rid=%0d lin=%0d ang=%0d mov=%0d got %0d %0d %0d %0d",
                     want.rid, want.lin, $signed(want.ang), want.mov,
                     robot_id, linear_cmd, angular_cmd, moving);
        end
      end
    end
  end

  // Receiver stall: mostly short gaps, plus one long hold-off on request
  initial begin
    int g;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_long = 0;
      end
      g = gap_len();
      out_stall <= (g > 0);
      repeat (g > 0 ? g : $urandom_range(1, 30)) @(posedge clk);
    end
  end

  // Watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_two_robot_pursuit_controller_top: done, errors");
      $finish;
    end
  end

  initial begin
    sample_row_t rows[$];
    cmd_t none, zero_a, zero_b;
    none = '{0, 0, 0, 0};
    zero_a = '{0, 0, 0, 0};
    zero_b = '{1, 0, 0, 0};
    predictor_reset();
    // first samples: both poses at the origin, so commands are zero
    rows.push_back('{0, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 1, zero_a});
    rows.push_back('{1, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 1, zero_b});
    // extremes of displacement: pose saturation both ways
    rows.push_back('{0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 0, none});
    rows.push_back('{1, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 0, none});
    rows.push_back('{0, 32'h0001_0000, 32'h0000_0000, 16'h4000, 0, none});
    rows.push_back('{1, 32'h0000_0000, 32'hFFFF_0000, 16'hC000, 0, none});
    rows.push_back('{0, 32'h0000_0000, 32'h0000_0000, 16'h8000, 0, none});
    rows.push_back('{1, 32'h0000_8000, 32'h0000_8000, 16'h0001, 0, none});
    rows.push_back('{0, 32'hFFFF_FFFF, 32'h0000_0001, 16'h2000, 0, none});
    rows.push_back('{1, 32'h1234_5678, 32'h9ABC_DEF0, 16'hA5A5, 0, none});
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      send_sample(rows[i].act, rows[i].x, rows[i].y, rows[i].h, rows[i].known, rows[i].cmd);
    end
    drain();

    // Several register settings, extremes among them
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_START_A, 48'h0100_FF00_4000);
          write_reg(REG_START_B, 48'hFF00_0100_C000);
          write_reg(REG_DIST_GN, 48'hFFFF);
          write_reg(REG_TURN_GN, 48'hFFFF);
          write_reg(REG_STOP, 48'd0);
        end
        1: begin
          write_reg(REG_START_A, 48'h7FFF_8000_FFFF);
          write_reg(REG_START_B, 48'h8000_7FFF_0000);
          write_reg(REG_DIST_GN, 48'd0);
          write_reg(REG_TURN_GN, 48'd0);
          write_reg(REG_STOP, 48'h7FFF_FFFF);
        end
        2: begin
          write_reg(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
          write_reg(REG_STOP, 48'd6554);
          write_reg(REG_DIST_GN, 48'd256);
          write_reg(REG_TURN_GN, 48'd256);
        end
        default: begin
          write_reg(REG_START_A, {$urandom(), 16'($urandom())});
          write_reg(REG_START_B, {$urandom(), 16'($urandom())});
          write_reg(REG_DIST_GN, 48'($urandom_range(0, 65535)));
          write_reg(REG_TURN_GN, 48'($urandom_range(0, 65535)));
          write_reg(REG_STOP, 48'($urandom_range(0, 32'h0004_0000)));
        end
      endcase
      cfg_we <= 1'b0;
      if (phase == 3) hold_long = 1;
      repeat (300) send_with_gap($urandom_range(0, 1), rand_pos(), rand_pos(), $urandom());
      drain();
    end

    if (mismatches == 0 && pending_cmds.size() == 0)
      $display("tb_two_robot_pursuit_controller_top: done, clean");
    else
      $display("tb_two_robot_pursuit_controller_top: done, errors");
    $finish;
  end

endmodule
